// ----- hdl/bmw_pkg.sv -----
package bmw_pkg;

  localparam int MaxRadius = 3;
  localparam int RingRows  = 2 * MaxRadius + 1;
  localparam int NumCells  = 2 * MaxRadius;
  localparam int RingW     = $clog2(RingRows);
  localparam int MaxHeight = 4096;
  localparam int PixW      = 8;
  localparam int ColOutW   = 10;
  localparam int RowW      = 12;
  localparam int HgtW      = 13;
  localparam int CfgDataW  = 13;

  localparam logic [PixW-1:0] PixFull = 8'hFF;
  localparam logic [PixW-1:0] PixZero = 8'h00;

  localparam logic ActPixel = 1'b0;
  localparam logic ActDrain = 1'b1;

  typedef enum logic [2:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgDilateMode  = 3'd2,
    CfgRadius      = 3'd3,
    CfgXLow        = 3'd4,
    CfgXHigh       = 3'd5,
    CfgYLow        = 3'd6,
    CfgYHigh       = 3'd7
  } cfg_reg_e;

  typedef logic [RingRows-1:0] flags_t;
  typedef logic [RingW-1:0]    ring_t;
  typedef logic [RingW:0]      ring_sum_t;
  typedef logic signed [15:0]  region_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } lb_ctrl_t;

  // slot of the row k lines above the row held in slot ring
  function automatic ring_t ring_back(ring_t ring, ring_t k);
    ring_sum_t s;
    s = ring_sum_t'(ring) + ring_sum_t'(RingRows) - ring_sum_t'(k);
    if (s >= ring_sum_t'(RingRows)) s = s - ring_sum_t'(RingRows);
    return s[RingW-1:0];
  endfunction

endpackage

// ----- hdl/bmw_line_buf.sv -----
module bmw_line_buf #(
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  bmw_pkg::lb_ctrl_t        ctrl_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [bmw_pkg::PixW-1:0] wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_a_addr_i,
  input  logic [$clog2(Depth)-1:0] rd_b_addr_i,
  output logic [bmw_pkg::PixW-1:0] rd_a_data_o,
  output logic [bmw_pkg::PixW-1:0] rd_b_data_o
);
  import bmw_pkg::*;

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rd_a_q;
  logic [PixW-1:0] rd_b_q;

  // reads return the contents from before a write at the same edge
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_a_q <= mem_q[rd_a_addr_i];
      rd_b_q <= mem_q[rd_b_addr_i];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

// ----- hdl/bmw_cell.sv -----
module bmw_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  bmw_pkg::flags_t flags_i,
  input  bmw_pkg::flags_t mask_i,
  output bmw_pkg::flags_t flags_o,
  output logic            hit_o
);
  import bmw_pkg::*;

  flags_t flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (shift_i) begin
      flags_q <= flags_i;
    end
  end

  assign flags_o = flags_q;
  assign hit_o   = |(flags_q & mask_i);

endmodule

// ----- hdl/binary_morphology_window.sv -----
// Square-window dilate/erode filter over a raster pixel stream. The block takes one
// beat per clock while the output is not stalled; each pixel or drain beat occupies one
// raster position, and the pixel at position k leaves on the beat at position
// k + radius*width + radius, passing through the registered line-store read and then the
// output register. The rate is set by the line store, seven row buffers of MAX_WIDTH
// pixels that each take one write and two reads per clock, and by the chain of six column
// cells that shifts once per beat and is ORed with the freshly read column in the same
// cycle. The line store has no clearing pass after reset: pixels never written read back
// as whatever the buffers hold, which only shows in windows that cover positions skipped
// by drain beats. After the beat marked frame_end is produced, beats are dropped until one
// arrives with frame_start set.
module binary_morphology_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  bmw_pkg::cfg_reg_e            cfg_index_i,
  input  logic [bmw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic                         frame_start_i,
  input  logic [7:0]                   pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   pixel_out_o,
  output logic [9:0]                   column_o,
  output logic [11:0]                  row_o,
  output logic                         frame_end_o
);
  import bmw_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WdW  = $clog2(MAX_WIDTH + 1);
  localparam int DlyW = $clog2(MaxRadius * MAX_WIDTH + MaxRadius + 1);

  // configuration
  logic [10:0] image_width_q;
  logic [12:0] image_height_q;
  logic        dilate_mode_q;
  logic [1:0]  window_radius_q;
  logic [9:0]  region_x_low_q;
  logic [9:0]  region_x_high_q;
  logic [11:0] region_y_low_q;
  logic [11:0] region_y_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= 11'd1024;
      image_height_q  <= 13'd4096;
      dilate_mode_q   <= 1'b1;
      window_radius_q <= 2'd1;
      region_x_low_q  <= 10'd0;
      region_x_high_q <= 10'd1023;
      region_y_low_q  <= 12'd0;
      region_y_high_q <= 12'd4095;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgImageWidth:  image_width_q   <= cfg_data_i[10:0];
        CfgImageHeight: image_height_q  <= cfg_data_i[12:0];
        CfgDilateMode:  dilate_mode_q   <= cfg_data_i[0];
        CfgRadius:      window_radius_q <= cfg_data_i[1:0];
        CfgXLow:        region_x_low_q  <= cfg_data_i[9:0];
        CfgXHigh:       region_x_high_q <= cfg_data_i[9:0];
        CfgYLow:        region_y_low_q  <= cfg_data_i[11:0];
        CfgYHigh:       region_y_high_q <= cfg_data_i[11:0];
      endcase
    end
  end

  // effective geometry
  logic [1:0]      r_eff;
  logic [WdW-1:0]  eff_w;
  logic [HgtW-1:0] eff_h;
  logic [DlyW-1:0] delay;

  always_comb begin
    r_eff = (window_radius_q == 2'd0) ? 2'd1 : window_radius_q;
    if (image_width_q == 11'd0) begin
      eff_w = WdW'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      eff_w = WdW'(MAX_WIDTH);
    end else begin
      eff_w = WdW'(image_width_q);
    end
    if (image_height_q == 13'd0) begin
      eff_h = HgtW'(1);
    end else if (32'(image_height_q) > MaxHeight) begin
      eff_h = HgtW'(MaxHeight);
    end else begin
      eff_h = image_height_q;
    end
    delay = DlyW'(r_eff) * DlyW'(eff_w) + DlyW'(r_eff);
  end

  // raster state
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  ring_t           in_ring_q, in_ring_d, out_ring_q, out_ring_d;
  logic [DlyW-1:0] lead_q, lead_d;
  logic            running_q, running_d;

  logic            in_acc, live, emit, last;
  logic [ColW-1:0] in_col_c, out_col_c;
  logic [RowW-1:0] in_row_c, out_row_c;
  ring_t           in_ring_c, out_ring_c;
  logic [DlyW-1:0] lead_c;
  logic            running_c;
  logic            in_region, bypass;
  region_t         rr, ox, oy, xlo, xhi, ylo, yhi;

  // stage 1
  logic            s1_valid_q, s1_valid_d;
  logic            s1_has_pix_q;
  logic [PixW-1:0] s1_pix_q;
  ring_t           s1_ring_q, s1_out_ring_q;
  logic            s1_emit_q, s1_region_q, s1_bypass_q, s1_last_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic            s1_adv;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [PixW-1:0] out_pix_q;
  logic [ColW-1:0] out_col_o_q;
  logic [RowW-1:0] out_row_o_q;
  logic            out_last_q;

  assign s1_adv     = s1_valid_q && (!s1_emit_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    in_col_c   = frame_start_i ? '0 : in_col_q;
    in_row_c   = frame_start_i ? '0 : in_row_q;
    in_ring_c  = frame_start_i ? '0 : in_ring_q;
    out_col_c  = frame_start_i ? '0 : out_col_q;
    out_row_c  = frame_start_i ? '0 : out_row_q;
    out_ring_c = frame_start_i ? '0 : out_ring_q;
    lead_c     = frame_start_i ? '0 : lead_q;
    running_c  = frame_start_i || running_q;
    live       = in_acc && running_c;
    emit       = lead_c >= delay;
    last       = ((WdW'(out_col_c) + WdW'(1)) >= eff_w)
              && ((HgtW'(out_row_c) + HgtW'(1)) >= eff_h);
    bypass     = (action_i == ActPixel) && (in_ring_c == out_ring_c)
              && (in_col_c == out_col_c);

    // region clamped so the whole window stays inside the frame
    rr  = region_t'(r_eff);
    ox  = region_t'(out_col_c);
    oy  = region_t'(out_row_c);
    xlo = region_t'(region_x_low_q);
    xhi = region_t'(region_x_high_q);
    ylo = region_t'(region_y_low_q);
    yhi = region_t'(region_y_high_q);
    if (xlo < rr) xlo = rr;
    if (ylo < rr) ylo = rr;
    if (xhi > region_t'(eff_w) - rr - region_t'(1)) xhi = region_t'(eff_w) - rr - region_t'(1);
    if (yhi > region_t'(eff_h) - rr - region_t'(1)) yhi = region_t'(eff_h) - rr - region_t'(1);
    in_region = (ox >= xlo) && (ox <= xhi) && (oy >= ylo) && (oy <= yhi);

    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_ring_d  = in_ring_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_ring_d = out_ring_q;
    lead_d     = lead_q;
    running_d  = running_q;
    if (in_acc && frame_start_i) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_ring_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_ring_d = '0;
      lead_d     = '0;
      running_d  = 1'b1;
    end
    if (live) begin
      if ((WdW'(in_col_c) + WdW'(1)) >= eff_w) begin
        in_col_d  = '0;
        in_row_d  = in_row_c + RowW'(1);
        if (in_row_c == '1 || in_ring_c == ring_t'(RingRows - 1)) begin
          in_ring_d = '0;
        end else begin
          in_ring_d = in_ring_c + ring_t'(1);
        end
      end else begin
        in_col_d = in_col_c + ColW'(1);
      end
      if (emit) begin
        if ((WdW'(out_col_c) + WdW'(1)) >= eff_w) begin
          out_col_d = '0;
          out_row_d = out_row_c + RowW'(1);
          if (out_row_c == '1 || out_ring_c == ring_t'(RingRows - 1)) begin
            out_ring_d = '0;
          end else begin
            out_ring_d = out_ring_c + ring_t'(1);
          end
        end else begin
          out_col_d = out_col_c + ColW'(1);
        end
        if (last) running_d = 1'b0;
      end else begin
        lead_d = lead_c + DlyW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
      lead_q     <= '0;
      running_q  <= 1'b1;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_ring_q  <= in_ring_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_ring_q <= out_ring_d;
      lead_q     <= lead_d;
      running_q  <= running_d;
    end
  end

  // line store: one buffer per ring slot
  lb_ctrl_t        lb_ctrl [RingRows];
  logic [PixW-1:0] rd_a [RingRows];
  logic [PixW-1:0] rd_b [RingRows];

  for (genvar m = 0; m < RingRows; m++) begin : g_lb
    assign lb_ctrl[m].wr_en = live && (action_i == ActPixel) && (in_ring_c == ring_t'(m));
    assign lb_ctrl[m].rd_en = live;

    bmw_line_buf #(
      .Depth(MAX_WIDTH)
    ) u_line_buf (
      .clk_i      (clk_i),
      .ctrl_i     (lb_ctrl[m]),
      .wr_addr_i  (in_col_c),
      .wr_data_i  (pixel_in_i),
      .rd_a_addr_i(in_col_c),
      .rd_b_addr_i(out_col_c),
      .rd_a_data_o(rd_a[m]),
      .rd_b_data_o(rd_b[m])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  assign s1_valid_d = live ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i) begin
    if (live) begin
      s1_has_pix_q  <= (action_i == ActPixel);
      s1_pix_q      <= pixel_in_i;
      s1_ring_q     <= in_ring_c;
      s1_out_ring_q <= out_ring_c;
      s1_emit_q     <= emit;
      s1_region_q   <= in_region;
      s1_bypass_q   <= bypass;
      s1_col_q      <= out_col_c;
      s1_row_q      <= out_row_c;
      s1_last_q     <= last;
    end
  end

  // column of hit flags for the beat in stage 1, row k lines above the input row
  flags_t          mem_flag, cur_flags, mask;
  flags_t          cell_flags [NumCells];
  logic [NumCells-1:0] cell_hit, cell_use;
  logic            hit;
  logic [PixW-1:0] center, filt;

  always_comb begin
    for (int m = 0; m < RingRows; m++) begin
      mem_flag[m] = (rd_a[m] != PixZero) == dilate_mode_q;
    end
    cur_flags[0] = s1_has_pix_q ? ((s1_pix_q != PixZero) == dilate_mode_q)
                                : mem_flag[s1_ring_q];
    for (int k = 1; k < RingRows; k++) begin
      cur_flags[k] = mem_flag[ring_back(s1_ring_q, ring_t'(k))];
    end
    for (int k = 0; k < RingRows; k++) begin
      mask[k] = k <= 2 * int'(r_eff);
    end
    for (int i = 0; i < NumCells; i++) begin
      cell_use[i] = i < 2 * int'(r_eff);
    end
    hit    = (|(cur_flags & mask)) || (|(cell_hit & cell_use));
    center = s1_bypass_q ? s1_pix_q : rd_b[s1_out_ring_q];
    if (s1_region_q && hit) begin
      filt = dilate_mode_q ? PixFull : PixZero;
    end else begin
      filt = center;
    end
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    bmw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(s1_adv),
      .flags_i((i == 0) ? cur_flags : cell_flags[(i == 0) ? 0 : i - 1]),
      .mask_i (mask),
      .flags_o(cell_flags[i]),
      .hit_o  (cell_hit[i])
    );
  end

  assign out_valid_d = (s1_adv && s1_emit_q) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_pix_q   <= filt;
      out_col_o_q <= s1_col_q;
      out_row_o_q <= s1_row_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign column_o    = ColOutW'(out_col_o_q);
  assign row_o       = out_row_o_q;
  assign frame_end_o = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live && emit && last |=> !running_q)
    else $error("frame end beat did not stop the stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_ring_q) < RingRows && 32'(out_ring_q) < RingRows)
    else $error("ring slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_col_q) < MAX_WIDTH && 32'(out_col_q) < MAX_WIDTH)
    else $error("raster column beyond line store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live && !emit |=> lead_q == $past(lead_c) + DlyW'(1))
    else $error("lead count did not advance");

endmodule

// ----- sim/binary_morphology_window_tb.sv -----
`timescale 1ns / 100ps

module binary_morphology_window_tb;
  import bmw_pkg::*;

  localparam int RamCols   = 1024;
  localparam int StallLimit = 5000;

  typedef struct {
    logic [7:0]  pix;
    logic [9:0]  col;
    logic [11:0] row;
    logic        last;
  } out_beat_t;

  logic                clk;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i   = CfgImageWidth;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                action_i      = ActPixel;
  logic                frame_start_i = 1'b0;
  logic [7:0]          pixel_in_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b1;
  logic [7:0]          pixel_out_o;
  logic [9:0]          column_o;
  logic [11:0]         row_o;
  logic                frame_end_o;

  // pixel stream model state
  logic [7:0]  ring_mem [RingRows][RamCols];
  int unsigned wr_col, wr_row, rd_col, rd_row, fill_cnt;
  bit          frame_live;
  int unsigned reg_val [8];
  logic [CfgDataW-1:0] cfg_next [8];

  out_beat_t   expected_beats [$];
  out_beat_t   head_beat;
  int          err_cnt;
  int          beats_sent;
  int          send_pct;
  int          stall_pct;
  int          quiet_cycles;

  binary_morphology_window DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .frame_start_i (frame_start_i),
    .pixel_in_i    (pixel_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_out_o   (pixel_out_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .frame_end_o   (frame_end_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (reg_val[CfgImageWidth] < 1) return 1;
    if (reg_val[CfgImageWidth] > RamCols) return RamCols;
    return reg_val[CfgImageWidth];
  endfunction

  function automatic int unsigned eff_height();
    if (reg_val[CfgImageHeight] < 1) return 1;
    if (reg_val[CfgImageHeight] > MaxHeight) return MaxHeight;
    return reg_val[CfgImageHeight];
  endfunction

  function automatic int unsigned eff_radius();
    if (reg_val[CfgRadius] < 1) return 1;
    if (reg_val[CfgRadius] > MaxRadius) return MaxRadius;
    return reg_val[CfgRadius];
  endfunction

  function automatic logic [7:0] ring_at(int unsigned row, int unsigned col);
    if (col >= RamCols) return PixZero;
    return ring_mem[row % RingRows][col];
  endfunction

  function automatic logic [7:0] window_value(int unsigned ox, int unsigned oy,
                                              int unsigned w, int unsigned h,
                                              int unsigned r);
    int         xlo, xhi, ylo, yhi, xlim, ylim;
    logic [7:0] orig, v;
    xlo  = int'(reg_val[CfgXLow]);
    xhi  = int'(reg_val[CfgXHigh]);
    ylo  = int'(reg_val[CfgYLow]);
    yhi  = int'(reg_val[CfgYHigh]);
    xlim = int'(w) - int'(r) - 1;
    ylim = int'(h) - int'(r) - 1;
    orig = ring_at(oy, ox);
    if (xlo < int'(r)) xlo = int'(r);
    if (ylo < int'(r)) ylo = int'(r);
    if (xhi > xlim) xhi = xlim;
    if (yhi > ylim) yhi = ylim;
    if (int'(ox) < xlo || int'(ox) > xhi || int'(oy) < ylo || int'(oy) > yhi) return orig;
    for (int unsigned dy = 0; dy <= 2 * r; dy++) begin
      for (int unsigned dx = 0; dx <= 2 * r; dx++) begin
        v = ring_at(oy - r + dy, ox - r + dx);
        if (reg_val[CfgDilateMode] != 0 && v != PixZero) return PixFull;
        if (reg_val[CfgDilateMode] == 0 && v == PixZero) return PixZero;
      end
    end
    return orig;
  endfunction

  task automatic predict_beat(input logic act, input logic fs, input logic [7:0] pix);
    int unsigned w, h, r, delay;
    bit          last;
    out_beat_t   b;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    delay = r * w + r;
    if (fs) begin
      wr_col = 0;
      wr_row = 0;
      rd_col = 0;
      rd_row = 0;
      fill_cnt = 0;
      frame_live = 1'b1;
    end
    if (!frame_live) return;
    if (act == ActPixel && wr_col < RamCols) ring_mem[wr_row % RingRows][wr_col] = pix;
    if (fill_cnt >= delay) begin
      last   = (rd_col + 1 >= w) && (rd_row + 1 >= h);
      b.pix  = window_value(rd_col, rd_row, w, h, r);
      b.col  = rd_col[9:0];
      b.row  = rd_row[11:0];
      b.last = last;
      expected_beats.push_back(b);
      rd_col++;
      if (rd_col >= w) begin
        rd_col = 0;
        rd_row = (rd_row + 1) & 12'hFFF;
      end
      if (last) frame_live = 1'b0;
    end else begin
      fill_cnt++;
    end
    wr_col++;
    if (wr_col >= w) begin
      wr_col = 0;
      wr_row = (wr_row + 1) & 12'hFFF;
    end
  endtask

  function automatic logic [7:0] rand_pixel(int zero_pct);
    if (int'($urandom_range(0, 99)) < zero_pct) return PixZero;
    if ($urandom_range(0, 1)) return PixFull;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_beat(input logic act, input logic fs, input logic [7:0] pix);
    while (int'($urandom_range(0, 99)) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    frame_start_i <= fs;
    pixel_in_i    <= pix;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    predict_beat(act, fs, pix);
    beats_sent++;
  endtask

  // drain the pipe, then load all registers from cfg_next
  task automatic write_config();
    cfg_reg_e idx;
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    idx = idx.first();
    do begin
      cfg_index_i <= idx;
      cfg_data_i  <= cfg_next[idx];
      cfg_valid_i <= 1'b1;
      @(posedge clk);
      while (!cfg_ready_o) @(posedge clk);
      reg_val[idx] = cfg_next[idx];
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned mode,
                            int unsigned r, int unsigned xl, int unsigned xh,
                            int unsigned yl, int unsigned yh);
    cfg_next[CfgImageWidth]  = w;
    cfg_next[CfgImageHeight] = h;
    cfg_next[CfgDilateMode]  = mode;
    cfg_next[CfgRadius]      = r;
    cfg_next[CfgXLow]        = xl;
    cfg_next[CfgXHigh]       = xh;
    cfg_next[CfgYLow]        = yl;
    cfg_next[CfgYHigh]       = yh;
    write_config();
  endtask

  task automatic rand_config();
    int unsigned w, h, ew, eh;
    w = $urandom_range(1, 16);
    h = $urandom_range(1, 10);
    if ($urandom_range(0, 19) == 0) w = 0;
    if ($urandom_range(0, 19) == 0) h = 0;
    // rare full-width line, kept one row high
    if ($urandom_range(0, 79) == 0) begin
      w = $urandom_range(0, 1) ? 2047 : 1024;
      h = 1;
    end
    ew = (w < 1) ? 1 : ((w > RamCols) ? RamCols : w);
    eh = (h < 1) ? 1 : h;
    cfg_next[CfgImageWidth]  = w;
    cfg_next[CfgImageHeight] = h;
    cfg_next[CfgDilateMode]  = $urandom_range(0, 1);
    cfg_next[CfgRadius]      = $urandom_range(0, 3);
    case ($urandom_range(0, 2))
      0: begin
        cfg_next[CfgXLow]  = 0;
        cfg_next[CfgXHigh] = 1023;
        cfg_next[CfgYLow]  = 0;
        cfg_next[CfgYHigh] = 4095;
      end
      1: begin
        cfg_next[CfgXLow]  = $urandom_range(0, ew) & 10'h3FF;
        cfg_next[CfgXHigh] = $urandom_range(0, ew + 1) & 10'h3FF;
        cfg_next[CfgYLow]  = $urandom_range(0, eh);
        cfg_next[CfgYHigh] = $urandom_range(0, eh + 1);
      end
      default: begin
        cfg_next[CfgXLow]  = $urandom & 10'h3FF;
        cfg_next[CfgXHigh] = $urandom & 10'h3FF;
        cfg_next[CfgYLow]  = $urandom & 12'hFFF;
        cfg_next[CfgYHigh] = $urandom & 12'hFFF;
      end
    endcase
    write_config();
  endtask

  // one frame plus its trailing drains, sometimes cut short or drained mid-frame
  task automatic run_frame();
    int unsigned w, h, r, n, total, cut, k, zero_pct, variant;
    logic        act;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    n = w * h;
    total = n + r * w + r;
    variant = $urandom_range(0, 9);
    cut = (variant == 0) ? $urandom_range(1, total - 1) : total;
    zero_pct = $urandom_range(0, 100);
    for (k = 0; k < cut; k++) begin
      act = ActPixel;
      if (k >= n) act = ActDrain;
      else if (variant == 1 && $urandom_range(0, 9) == 0) act = ActDrain;
      else if (k == 0 && $urandom_range(0, 9) == 0) act = ActDrain;
      send_beat(act, k == 0, rand_pixel(zero_pct));
    end
    if (cut < total) begin
      // reconfigure in the middle of the frame and keep streaming
      if ($urandom_range(0, 1)) begin
        rand_config();
        repeat ($urandom_range(1, 30)) send_beat($urandom_range(0, 1), 1'b0,
                                                 rand_pixel(zero_pct));
      end
    end else begin
      repeat ($urandom_range(0, 3)) send_beat($urandom_range(0, 1), 1'b0, 8'($urandom));
    end
  endtask

  // fills every line-store entry with the first rows of a frame at full width
  task automatic test_full_width_frame();
    send_pct  = 32;
    stall_pct = 32;
    for (int k = 0; k < RingRows * RamCols; k++) send_beat(ActPixel, k == 0, 8'($urandom));
  endtask

  // width and height above and below range; rows run out to the last one
  task automatic test_tall_clamped_frame();
    send_pct  = 0;
    stall_pct = 0;
    set_config(0, 8191, 0, 0, 1023, 0, 4095, 0);
    for (int k = 0; k < MaxHeight; k++) send_beat(ActPixel, k == 0, 8'($urandom));
    send_beat(ActDrain, 1'b0, PixZero);
    send_beat(ActDrain, 1'b0, PixFull);
    send_beat(ActPixel, 1'b0, PixFull);
    send_beat(ActDrain, 1'b0, PixZero);
  endtask

  task automatic test_corner_cases();
    send_pct  = 0;
    stall_pct = 0;
    // dilate: one set corner pixel lights the only interior pixel
    set_config(3, 3, 1, 0, 0, 1023, 0, 4095);
    for (int k = 0; k < 9; k++) send_beat(ActPixel, k == 0, (k == 8) ? 8'h01 : PixZero);
    repeat (4) send_beat(ActDrain, 1'b0, PixFull);
    // dropped after the frame is done
    send_beat(ActPixel, 1'b0, PixFull);
    // erode: frame opens on a drain, its stale zero clears the center
    set_config(3, 3, 0, 1, 0, 1023, 0, 4095);
    send_beat(ActDrain, 1'b1, PixFull);
    for (int k = 1; k < 9; k++) send_beat(ActPixel, 1'b0, PixFull);
    repeat (4) send_beat(ActDrain, 1'b0, PixZero);
  endtask

  task automatic test_random_traffic(int gap_pct, int hold_pct, int n_items);
    int start;
    send_pct  = gap_pct;
    stall_pct = hold_pct;
    start = beats_sent;
    rand_config();
    while (beats_sent - start < n_items) begin
      if ($urandom_range(0, 1)) rand_config();
      run_frame();
    end
  endtask

  always @(posedge clk) begin
    out_ready_i <= (stall_pct == 0) ? 1'b1 : (int'($urandom_range(0, 99)) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected beat: pix %0d col %0d row %0d end %0d",
                   pixel_out_o, column_o, row_o, frame_end_o);
      end else begin
        head_beat = expected_beats.pop_front();
        if (pixel_out_o !== head_beat.pix || column_o !== head_beat.col ||
            row_o !== head_beat.row || frame_end_o !== head_beat.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp pix %0d col %0d row %0d end %0d, got %0d %0d %0d %0d",
                     head_beat.pix, head_beat.col, head_beat.row, head_beat.last,
                     pixel_out_o, column_o, row_o, frame_end_o);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("binary_morphology_window_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (ring_mem[i, j]) ring_mem[i][j] = PixZero;
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
    fill_cnt = 0;
    frame_live = 1'b1;
    reg_val[CfgImageWidth]  = 1024;
    reg_val[CfgImageHeight] = 4096;
    reg_val[CfgDilateMode]  = 1;
    reg_val[CfgRadius]      = 1;
    reg_val[CfgXLow]        = 0;
    reg_val[CfgXHigh]       = 1023;
    reg_val[CfgYLow]        = 0;
    reg_val[CfgYHigh]       = 4095;
    err_cnt = 0;
    beats_sent = 0;
    send_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_full_width_frame();
    test_tall_clamped_frame();
    test_corner_cases();
    test_random_traffic(0, 0, 440);
    test_random_traffic(77, 0, 440);
    test_random_traffic(0, 77, 440);
    test_random_traffic(32, 32, 440);

    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0 && expected_beats.size() == 0) begin
      $display("binary_morphology_window_tb passed");
    end else begin
      $display("binary_morphology_window_tb failed");
    end
    $finish;
  end

endmodule
